// ===== hdl/sbp_pkg.sv =====
// Shared types and constants for the symbol-to-bits byte packer.
package sbp_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned StoreW = 10;
  localparam int unsigned HeldW  = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned ByteW  = 8;

  localparam logic [CountW-1:0] MaxBytesReset = 16'hFFFF;

  // Code characters, three-bit group first, two-bit group after.
  localparam logic [SymW-1:0] SymX      = 8'h58;
  localparam logic [SymW-1:0] SymA      = 8'h41;
  localparam logic [SymW-1:0] SymF      = 8'h66;
  localparam logic [SymW-1:0] SymB      = 8'h62;
  localparam logic [SymW-1:0] SymP      = 8'h50;
  localparam logic [SymW-1:0] SymD      = 8'h44;
  localparam logic [SymW-1:0] SymN      = 8'h4E;
  localparam logic [SymW-1:0] SymG      = 8'h67;
  localparam logic [SymW-1:0] SymK      = 8'h4B;
  localparam logic [SymW-1:0] SymDollar = 8'h24;
  localparam logic [SymW-1:0] SymFive   = 8'h35;
  localparam logic [SymW-1:0] SymM      = 8'h6D;

  typedef struct packed {
    logic       known;
    logic       three;  // 1: three-bit group, 0: two-bit group
    logic [2:0] code;
  } sym_dec_t;

  typedef struct packed {
    logic             byte_valid;
    logic [ByteW-1:0] data_byte;
    logic             bad_symbol;
    logic             limit_reached;
  } result_t;

endpackage

// ===== hdl/sbp_decode.sv =====
// Maps one code character to its bit group and width.
module sbp_decode (
  input  logic [sbp_pkg::SymW-1:0] symbol_i,
  output sbp_pkg::sym_dec_t        dec_o
);
  import sbp_pkg::*;

  always_comb begin
    dec_o = '{known: 1'b1, three: 1'b1, code: 3'd0};
    case (symbol_i)
      SymX:      dec_o.code = 3'd0;
      SymA:      dec_o.code = 3'd1;
      SymF:      dec_o.code = 3'd2;
      SymB:      dec_o.code = 3'd3;
      SymP:      dec_o.code = 3'd4;
      SymD:      dec_o.code = 3'd5;
      SymN:      dec_o.code = 3'd6;
      SymG:      dec_o.code = 3'd7;
      SymK:      begin dec_o.three = 1'b0; dec_o.code = 3'd0; end
      SymDollar: begin dec_o.three = 1'b0; dec_o.code = 3'd1; end
      SymFive:   begin dec_o.three = 1'b0; dec_o.code = 3'd2; end
      SymM:      begin dec_o.three = 1'b0; dec_o.code = 3'd3; end
      default:   dec_o = '{known: 1'b0, three: 1'b0, code: 3'd0};
    endcase
  end

endmodule

// ===== hdl/sbp_packer.sv =====
// Bit store, byte count and per-item result logic of the packer.
module sbp_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  sbp_pkg::sym_dec_t          dec_i,
  input  logic                       eom_i,
  input  logic [sbp_pkg::CountW-1:0] max_bytes_i,
  output sbp_pkg::result_t           res_o
);
  import sbp_pkg::*;

  logic [StoreW-1:0] store_q, store_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [CountW-1:0] made_q, made_d;

  logic [StoreW-1:0] shifted;
  logic [HeldW-1:0]  held_sum;
  logic [1:0]        rest;
  logic [StoreW-1:0] rest_mask;

  always_comb begin
    shifted   = dec_i.three ? {store_q[StoreW-4:0], dec_i.code}
                            : {store_q[StoreW-3:0], dec_i.code[1:0]};
    held_sum  = held_q + (dec_i.three ? HeldW'(3) : HeldW'(2));
    rest      = held_sum[1:0];  // only meaningful when held_sum is 8 to 10
    rest_mask = (StoreW'(1) << rest) - StoreW'(1);
  end

  always_comb begin
    store_d = store_q;
    held_d  = held_q;
    made_d  = made_q;
    res_o   = '{byte_valid: 1'b0, data_byte: '0, bad_symbol: 1'b0, limit_reached: 1'b0};
    if (made_q >= max_bytes_i) begin
      res_o.limit_reached = 1'b1;
    end else if (!dec_i.known) begin
      res_o.bad_symbol = 1'b1;
    end else if (held_sum >= HeldW'(8)) begin
      res_o.byte_valid = 1'b1;
      res_o.data_byte  = ByteW'(shifted >> rest);
      store_d          = shifted & rest_mask;
      held_d           = HeldW'(rest);
      made_d           = made_q + CountW'(1);
    end else begin
      store_d = shifted;
      held_d  = held_sum;
    end
    // End of message clears after the item is handled.
    if (eom_i) begin
      store_d = '0;
      held_d  = '0;
      made_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      held_q  <= '0;
      made_q  <= '0;
    end else if (step_i) begin
      store_q <= store_d;
      held_q  <= held_d;
      made_q  <= made_d;
    end
  end

endmodule

// ===== hdl/symbol_to_bits_byte_packer_unit.sv =====
// Top level of the symbol-to-bits byte packer: item registers and config.
//
// Input channel (in_valid_i/in_ready_o) carries one code character and an
// end-of-message flag per item. Output channel (out_valid_o/out_ready_i)
// returns exactly one result item per input item: an optional byte, plus
// flags for an unknown symbol or a symbol dropped at the byte limit.
// The user must write max_bytes through cfg_we_i/cfg_data_i only while the
// block is idle; the block itself does not enforce this.
//
// An accepted item goes into the input register, then the decode and pack
// logic loads the result register. The unit takes one item per cycle while
// the receiver does not stall; the pack state updates in the same cycle the
// item moves into the result register, so consecutive items chain.
// When the receiver stalls, the result register holds and the input register
// can still take one more item; in_ready_o then drops until the result moves.
// Reset empties both registers, clears the bit store and the byte count, and
// sets max_bytes to 65535.
module symbol_to_bits_byte_packer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sbp_pkg::SymW-1:0]   symbol_i,
  input  logic                       end_of_message_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       byte_valid_o,
  output logic [sbp_pkg::ByteW-1:0]  data_byte_o,
  output logic                       bad_symbol_o,
  output logic                       limit_reached_o,
  input  logic                       cfg_we_i,
  input  logic [sbp_pkg::CountW-1:0] cfg_data_i
);
  import sbp_pkg::*;

  logic [CountW-1:0] max_bytes_q;
  logic              in_vld_q;
  logic [SymW-1:0]   sym_q;
  logic              eom_q;
  logic              out_vld_q;
  result_t           res_q;
  result_t           res_d;
  sym_dec_t          dec;
  logic              advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
    end else if (cfg_we_i) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sym_q <= symbol_i;
      eom_q <= end_of_message_i;
    end
    if (advance) res_q <= res_d;
  end

  sbp_decode u_decode (
    .symbol_i (sym_q),
    .dec_o    (dec)
  );

  sbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .dec_i       (dec),
    .eom_i       (eom_q),
    .max_bytes_i (max_bytes_q),
    .res_o       (res_d)
  );

  assign out_valid_o     = out_vld_q;
  assign byte_valid_o    = res_q.byte_valid;
  assign data_byte_o     = res_q.data_byte;
  assign bad_symbol_o    = res_q.bad_symbol;
  assign limit_reached_o = res_q.limit_reached;

  // A result carries at most one of: byte, bad symbol, limit.
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({byte_valid_o, bad_symbol_o, limit_reached_o}))
    else $error("result carries more than one outcome");

  // No byte means the data field is zero.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (data_byte_o == '0))
    else $error("data byte nonzero without byte_valid");

  // A full input register with a stalled result must not accept a new item.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline is full");

endmodule
